FILE: src/bcs_pkg.sv
`default_nettype none

package bcs_pkg;

  // Widths of the payload fields and of the configuration port.
  localparam int unsigned CmdW     = 2;
  localparam int unsigned MvW      = 16;
  localparam int unsigned MaW      = 16;
  localparam int unsigned PhaseW   = 3;
  localparam int unsigned CountW   = 16;
  localparam int unsigned SecW     = 32;
  localparam int unsigned DelayW   = 32;
  localparam int unsigned MsW      = 10;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned RegIdxW  = 3;

  // One second is this many millisecond ticks.
  localparam logic [MsW-1:0] MsPerSecond = 10'd1000;

  // Register reset values.
  localparam logic [MvW-1:0]        DischargeStopMvRst = 16'd3000;
  localparam logic [MvW-1:0]        ChargeFullMvRst    = 16'd4200;
  localparam logic signed [MaW-1:0] ChargeFullMaRst    = 16'sd100;
  localparam logic [DelayW-1:0]     ConfirmDelayMsRst  = 32'd60000;
  localparam logic [CountW-1:0]     CycleTargetRst     = 16'd10;

  typedef enum logic [PhaseW-1:0] {
    PH_IDLE      = 3'd0,
    PH_DISCHARGE = 3'd1,
    PH_CHARGE    = 3'd2,
    PH_FINISHED  = 3'd3,
    PH_ERROR     = 3'd4
  } phase_e;

  typedef enum logic [CmdW-1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_FAULT = 2'd3
  } cmd_e;

  typedef enum logic [RegIdxW-1:0] {
    REG_DISCHARGE_STOP_MV = 3'd0,
    REG_CHARGE_FULL_MV    = 3'd1,
    REG_CHARGE_FULL_MA    = 3'd2,
    REG_CONFIRM_DELAY_MS  = 3'd3,
    REG_CYCLE_TARGET      = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [MvW-1:0]        discharge_stop_mv;
    logic [MvW-1:0]        charge_full_mv;
    logic signed [MaW-1:0] charge_full_ma;
    logic [DelayW-1:0]     confirm_delay_ms;
    logic [CountW-1:0]     cycle_target;
  } cfg_t;

  typedef struct packed {
    logic [CmdW-1:0]       command;
    logic [MvW-1:0]        voltage_mv;
    logic signed [MaW-1:0] current_ma;
  } item_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic              is_running;
    logic              charge_relay;
    logic              regulate_enable;
    logic              regulator_reset;
    logic [CountW-1:0] cycles_done;
    logic [SecW-1:0]   run_seconds;
  } result_t;

endpackage

`default_nettype wire

FILE: src/bcs_in_if.sv
`default_nettype none

interface bcs_in_if;
  logic                                valid;
  logic                                ready;
  logic [bcs_pkg::CmdW-1:0]            command;
  logic [bcs_pkg::MvW-1:0]             voltage_mv;
  logic signed [bcs_pkg::MaW-1:0]      current_ma;

  modport source (output valid, command, voltage_mv, current_ma, input ready);
  modport sink   (input valid, command, voltage_mv, current_ma, output ready);
endinterface

`default_nettype wire

FILE: src/bcs_out_if.sv
`default_nettype none

interface bcs_out_if;
  logic                           valid;
  logic                           ready;
  logic [bcs_pkg::PhaseW-1:0]     phase;
  logic                           is_running;
  logic                           charge_relay;
  logic                           regulate_enable;
  logic                           regulator_reset;
  logic [bcs_pkg::CountW-1:0]     cycles_done;
  logic [bcs_pkg::SecW-1:0]       run_seconds;

  modport source (output valid, phase, is_running, charge_relay, regulate_enable,
                  regulator_reset, cycles_done, run_seconds, input ready);
  modport sink   (input valid, phase, is_running, charge_relay, regulate_enable,
                  regulator_reset, cycles_done, run_seconds, output ready);
endinterface

`default_nettype wire

FILE: src/battery_cycle_sequencer.sv
// Path: each input item passes through the input register, then the result
// register; its result can be taken once it is valid, or later while the output
// stalls.
// Throughput: one item per cycle while the output is not stalled; the state update is the loop.
// Reset (rst_ni low, asynchronous): phase idle, counters cleared, relay on the
// discharge path, registers at their default values, no result pending.
`default_nettype none

module battery_cycle_sequencer (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  bcs_in_if.sink                              in_if,
  bcs_out_if.source                           out_if,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [bcs_pkg::ApbAddrW-1:0]   paddr,
  input  wire logic [bcs_pkg::ApbDataW-1:0]   pwdata,
  output logic      [bcs_pkg::ApbDataW-1:0]   prdata,
  output logic                                pready
);

  bcs_pkg::cfg_t     cfg;
  bcs_pkg::item_t    item_q;
  bcs_pkg::result_t  res_d, res_q;
  logic              in_valid_q;
  logic              out_valid_q;
  logic              advance;

  // An item advances when the result register is empty or being drained.
  assign advance     = in_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = !in_valid_q || advance;

  bcs_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bcs_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .cfg_i     (cfg),
    .item_i    (item_q),
    .result_o  (res_d)
  );

  // Input register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_q <= in_if.valid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      item_q.command    <= in_if.command;
      item_q.voltage_mv <= in_if.voltage_mv;
      item_q.current_ma <= in_if.current_ma;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_if.valid           = out_valid_q;
  assign out_if.phase           = res_q.phase;
  assign out_if.is_running      = res_q.is_running;
  assign out_if.charge_relay    = res_q.charge_relay;
  assign out_if.regulate_enable = res_q.regulate_enable;
  assign out_if.regulator_reset = res_q.regulator_reset;
  assign out_if.cycles_done     = res_q.cycles_done;
  assign out_if.run_seconds     = res_q.run_seconds;

endmodule

`default_nettype wire

FILE: src/bcs_cfg_regs.sv
`default_nettype none

module bcs_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [bcs_pkg::ApbAddrW-1:0]   paddr,
  input  wire logic [bcs_pkg::ApbDataW-1:0]   pwdata,
  output logic      [bcs_pkg::ApbDataW-1:0]   prdata,
  output logic                                pready,
  output bcs_pkg::cfg_t                       cfg_o
);

  bcs_pkg::cfg_t            cfg_q;
  bcs_pkg::reg_idx_e        reg_idx;
  logic                     wr_en;

  // Registers sit on word addresses; the low two address bits are ignored.
  assign reg_idx = bcs_pkg::reg_idx_e'(paddr[bcs_pkg::ApbAddrW-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register file, written in the access phase of a write transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.discharge_stop_mv <= bcs_pkg::DischargeStopMvRst;
      cfg_q.charge_full_mv    <= bcs_pkg::ChargeFullMvRst;
      cfg_q.charge_full_ma    <= bcs_pkg::ChargeFullMaRst;
      cfg_q.confirm_delay_ms  <= bcs_pkg::ConfirmDelayMsRst;
      cfg_q.cycle_target      <= bcs_pkg::CycleTargetRst;
    end else if (wr_en) begin
      unique case (reg_idx)
        bcs_pkg::REG_DISCHARGE_STOP_MV: cfg_q.discharge_stop_mv <= pwdata[15:0];
        bcs_pkg::REG_CHARGE_FULL_MV:    cfg_q.charge_full_mv    <= pwdata[15:0];
        bcs_pkg::REG_CHARGE_FULL_MA:    cfg_q.charge_full_ma    <= $signed(pwdata[15:0]);
        bcs_pkg::REG_CONFIRM_DELAY_MS:  cfg_q.confirm_delay_ms  <= pwdata;
        bcs_pkg::REG_CYCLE_TARGET:      cfg_q.cycle_target      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read data mux; unused addresses read as zero.
  always_comb begin
    unique case (reg_idx)
      bcs_pkg::REG_DISCHARGE_STOP_MV: prdata = {16'd0, cfg_q.discharge_stop_mv};
      bcs_pkg::REG_CHARGE_FULL_MV:    prdata = {16'd0, cfg_q.charge_full_mv};
      bcs_pkg::REG_CHARGE_FULL_MA:    prdata = {{16{cfg_q.charge_full_ma[15]}},
                                                cfg_q.charge_full_ma};
      bcs_pkg::REG_CONFIRM_DELAY_MS:  prdata = cfg_q.confirm_delay_ms;
      bcs_pkg::REG_CYCLE_TARGET:      prdata = {16'd0, cfg_q.cycle_target};
      default:                        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: src/bcs_step.sv
`default_nettype none

module bcs_step (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              advance_i,
  input  wire bcs_pkg::cfg_t     cfg_i,
  input  wire bcs_pkg::item_t    item_i,
  output bcs_pkg::result_t       result_o
);

  bcs_pkg::phase_e                phase_q, phase_d;
  logic                           running_q, running_d;
  logic                           relay_q, relay_d;
  logic [bcs_pkg::MsW-1:0]        ms_q, ms_d;
  logic [bcs_pkg::SecW-1:0]       sec_q, sec_d;
  logic                           full_act_q, full_act_d;
  logic [bcs_pkg::DelayW-1:0]     full_cnt_q, full_cnt_d;
  logic [bcs_pkg::CountW-1:0]     cycle_q, cycle_d;
  logic                           reg_en, reg_rst;
  logic                           full_met;
  logic [bcs_pkg::MsW-1:0]        ms_inc;
  bcs_pkg::cmd_e                  cmd;

  assign cmd      = bcs_pkg::cmd_e'(item_i.command);
  assign full_met = (item_i.voltage_mv >= cfg_i.charge_full_mv) &&
                    (item_i.current_ma <= cfg_i.charge_full_ma);
  assign ms_inc   = ms_q + 1'b1;

  // Next state and per-item outputs for the item in the input register.
  always_comb begin
    phase_d    = phase_q;
    running_d  = running_q;
    relay_d    = relay_q;
    ms_d       = ms_q;
    sec_d      = sec_q;
    full_act_d = full_act_q;
    full_cnt_d = full_cnt_q;
    cycle_d    = cycle_q;
    reg_en     = 1'b0;
    reg_rst    = 1'b0;

    unique case (cmd) inside
      bcs_pkg::CMD_START: begin
        reg_rst    = 1'b1;
        relay_d    = 1'b0;
        cycle_d    = '0;
        sec_d      = '0;
        ms_d       = '0;
        full_act_d = 1'b0;
        full_cnt_d = '0;
        phase_d    = bcs_pkg::PH_DISCHARGE;
        running_d  = 1'b1;
      end
      bcs_pkg::CMD_STOP, bcs_pkg::CMD_FAULT: begin
        reg_rst    = 1'b1;
        running_d  = 1'b0;
        full_act_d = 1'b0;
        full_cnt_d = '0;
        phase_d    = (cmd == bcs_pkg::CMD_STOP) ? bcs_pkg::PH_IDLE : bcs_pkg::PH_ERROR;
      end
      default: begin
        // Elapsed time advances only during a run.
        if (running_q) begin
          if (ms_inc >= bcs_pkg::MsPerSecond) begin
            ms_d = '0;
            if (sec_q != '1) begin
              sec_d = sec_q + 1'b1;
            end
          end else begin
            ms_d = ms_inc;
          end
        end

        unique case (phase_q)
          bcs_pkg::PH_DISCHARGE: begin
            reg_en = 1'b1;
            if (item_i.voltage_mv <= cfg_i.discharge_stop_mv) begin
              reg_rst    = 1'b1;
              relay_d    = 1'b1;
              full_act_d = 1'b0;
              full_cnt_d = '0;
              phase_d    = bcs_pkg::PH_CHARGE;
            end
          end
          bcs_pkg::PH_CHARGE: begin
            if (full_met) begin
              if (!full_act_q) begin
                full_act_d = 1'b1;
                full_cnt_d = '0;
              end else if (full_cnt_q != '1) begin
                full_cnt_d = full_cnt_q + 1'b1;
              end
              // The full condition has held long enough: the cycle is complete.
              if (full_cnt_d >= cfg_i.confirm_delay_ms) begin
                if (cycle_q != '1) begin
                  cycle_d = cycle_q + 1'b1;
                end
                if (cycle_d >= cfg_i.cycle_target) begin
                  phase_d = bcs_pkg::PH_FINISHED;
                end else begin
                  reg_rst    = 1'b1;
                  relay_d    = 1'b0;
                  full_act_d = 1'b0;
                  full_cnt_d = '0;
                  phase_d    = bcs_pkg::PH_DISCHARGE;
                end
              end
            end else begin
              full_act_d = 1'b0;
              full_cnt_d = '0;
            end
          end
          bcs_pkg::PH_FINISHED: begin
            if (running_q) begin
              running_d  = 1'b0;
              reg_rst    = 1'b1;
              full_act_d = 1'b0;
              full_cnt_d = '0;
            end
          end
          default: ;
        endcase
      end
    endcase
  end

  // Sequencer state, updated when an item moves into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= bcs_pkg::PH_IDLE;
      running_q  <= 1'b0;
      relay_q    <= 1'b0;
      ms_q       <= '0;
      sec_q      <= '0;
      full_act_q <= 1'b0;
      full_cnt_q <= '0;
      cycle_q    <= '0;
    end else if (advance_i) begin
      phase_q    <= phase_d;
      running_q  <= running_d;
      relay_q    <= relay_d;
      ms_q       <= ms_d;
      sec_q      <= sec_d;
      full_act_q <= full_act_d;
      full_cnt_q <= full_cnt_d;
      cycle_q    <= cycle_d;
    end
  end

  // The result reports the state after the item.
  always_comb begin
    result_o.phase           = phase_d;
    result_o.is_running      = running_d;
    result_o.charge_relay    = relay_d;
    result_o.regulate_enable = reg_en;
    result_o.regulator_reset = reg_rst;
    result_o.cycles_done     = cycle_d;
    result_o.run_seconds     = sec_d;
  end

endmodule

`default_nettype wire
